FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the read dispatch scheduler.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define CHK_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("scheduler check failed");

// condition must never be seen outside reset
`define CHK_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("scheduler check failed");

`endif

FILE: rtl/core/frds_pkg.sv
// ---------------------------------------------------------------------------
// frds_pkg
// Types and fixed constants of the flash read dispatch scheduler.
// ---------------------------------------------------------------------------
package frds_pkg;

   typedef enum logic [1:0] {
      CMD_NEW_READ  = 2'd0,
      CMD_DIE_DONE  = 2'd1,
      CMD_CH_DONE   = 2'd2,
      CMD_HOST_DONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ACT_DIE_READ  = 2'd0,
      ACT_CH_XFER   = 2'd1,
      ACT_HOST_XFER = 2'd2
   } action_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [8:0]  tag;
      logic [13:0] lba;
      logic [3:0]  sectors;
   } req_type;

   typedef struct packed {
      action_type  action;
      logic [8:0]  out_tag;
      logic [3:0]  channel;
      logic [1:0]  die;
      logic        last;
   } rsp_type;

   localparam int EV_TAG_W = 12;
   localparam int EV_CH_W  = 5;
   localparam int EV_DIE_W = 4;

   // classified event handed from front to back
   typedef struct packed {
      cmd_type               cmd;
      logic [EV_TAG_W-1:0]   tag;
      logic [EV_CH_W-1:0]    ch;
      logic [EV_DIE_W-1:0]   die;
      logic [3:0]            sectors;
   } ev_type;

   localparam int CAP_W        = 31;
   localparam int LIMIT_W      = 4;
   localparam int COUNT_W      = 10;
   localparam int BYTES_W      = 13;
   localparam int N_W          = 6;
   localparam int EVQ_DEPTH    = 2;
   localparam int CSR_IDX_W    = 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = 10'd1023;
   localparam logic [CAP_W-1:0]   USED_MAX    = 31'h7FFF_FFFF;
   localparam logic [CAP_W-1:0]   CAP_RESET   = 31'd536870912;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd2;
   localparam logic [N_W-1:0]     MAX_RESULTS = 6'd33;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIE_LIMIT = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVT,
      ST_PUSH_DIE,
      ST_TAG,
      ST_CNT,
      ST_HOST,
      ST_HOST_POP,
      ST_CH_FIND,
      ST_CH_TAG,
      ST_CH_CNT,
      ST_DIE_FIND,
      ST_DIE_HEAD,
      ST_DIE_POP,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/core/frds_front.sv
// ---------------------------------------------------------------------------
// frds_front
// Accepts event beats, reduces tag and splits lba into channel and die,
// and holds them in a short queue for the dispatch engine.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frds_front #(
   parameter int NUM_DIES     = 4,
   parameter int NUM_CHANNELS = 16,
   parameter int NUM_TAGS     = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  frds_pkg::req_type req_data,
   output logic             ev_valid,
   output frds_pkg::ev_type  ev_data,
   input  logic             ev_pop
);
   import frds_pkg::*;

   localparam int PTR_W = $clog2(EVQ_DEPTH);
   localparam int CNT_W = $clog2(EVQ_DEPTH + 1);

   ev_type             q_ff [EVQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   ev_type             ev_in;
   logic               push;

   always_comb begin
      int die_i;
      int ch_i;
      int tag_i;
      die_i = int'(req_data.lba) % NUM_DIES;
      ch_i  = (int'(req_data.lba) / NUM_DIES) % NUM_CHANNELS;
      tag_i = int'(req_data.tag) % NUM_TAGS;
      ev_in.cmd     = req_data.cmd;
      ev_in.tag     = EV_TAG_W'(tag_i);
      ev_in.ch      = EV_CH_W'(ch_i);
      ev_in.die     = EV_DIE_W'(die_i);
      ev_in.sectors = req_data.sectors;
   end

   assign busy     = (count_ff == CNT_W'(EVQ_DEPTH));
   assign push     = start && !busy;
   assign ev_valid = (count_ff != '0);
   assign ev_data  = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= ev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(EVQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (ev_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(EVQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(ev_pop);
      end
   end

   `CHK_HOLDS(a_pop_has_data, clock, reset, ev_pop |-> ev_valid)

endmodule

FILE: rtl/core/frds_back.sv
// ---------------------------------------------------------------------------
// frds_back
// Dispatch engine: applies one event to the tag lists and busy marks, then
// dispatches host, channels and dies in order, one result beat per step.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frds_back #(
   parameter int NUM_DIES     = 4,
   parameter int NUM_CHANNELS = 16,
   parameter int NUM_TAGS     = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            ev_valid,
   input  frds_pkg::ev_type                 ev_data,
   output logic                            ev_pop,
   input  logic [frds_pkg::CAP_W-1:0]      cap,
   input  logic [frds_pkg::LIMIT_W-1:0]    limit,
   output logic                            rsp_strobe,
   output frds_pkg::rsp_type                rsp_data
);
   import frds_pkg::*;

   localparam int TAG_W = $clog2(NUM_TAGS);
   localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int DIE_W = (NUM_DIES > 1) ? $clog2(NUM_DIES) : 1;
   localparam int LOC_W = CH_W + DIE_W;
   localparam int LOCS  = 1 << LOC_W;

   state_type state_ff, state_in;

   ev_type              ev_ff;
   logic [LOC_W-1:0]    loc_ff;
   logic [N_W-1:0]      n_ff;
   logic [CH_W:0]       ch_cur_ff;
   logic [CH_W-1:0]     ch_sel_ff;
   logic [LOC_W:0]      loc_cur_ff;
   logic [LOC_W-1:0]    loc_sel_ff;

   logic [LOCS-1:0]          dq_valid_ff;
   logic [LOCS-1:0]          die_busy_ff;
   logic [LOCS-1:0]          cnt_valid_ff;
   logic [NUM_CHANNELS-1:0]  ch_busy_ff;
   logic [NUM_CHANNELS-1:0]  chq_valid_ff;
   logic [TAG_W-1:0]         chq_head_ff [NUM_CHANNELS];
   logic [TAG_W-1:0]         chq_tail_ff [NUM_CHANNELS];
   logic                     hq_valid_ff;
   logic [TAG_W-1:0]         hq_head_ff;
   logic [TAG_W-1:0]         hq_tail_ff;
   logic                     host_busy_ff;
   logic [CAP_W-1:0]         used_ff;

   // tag memories
   logic [TAG_W-1:0]    link_mem [NUM_TAGS];
   logic [LOC_W-1:0]    tloc_mem [NUM_TAGS];
   logic [3:0]          tlen_mem [NUM_TAGS];
   logic [TAG_W-1:0]    link_rd_ff;
   logic [LOC_W-1:0]    tloc_rd_ff;
   logic [3:0]          tlen_rd_ff;

   // die memories
   logic [TAG_W-1:0]    dhead_mem [LOCS];
   logic [TAG_W-1:0]    dtail_mem [LOCS];
   logic [COUNT_W-1:0]  cnt_mem   [LOCS];
   logic [TAG_W-1:0]    dhead_rd_ff;
   logic [TAG_W-1:0]    dtail_rd_ff;
   logic [COUNT_W-1:0]  cnt_rd_ff;
   logic                cnt_vld_rd_ff;

   logic                pend_valid_ff;
   rsp_type             pend_ff;
   rsp_type             pend_last;
   logic                rsp_strobe_ff;
   rsp_type             rsp_ff;

   logic [TAG_W-1:0]    ev_tag;
   logic [LOC_W-1:0]    new_loc;
   logic [CH_W-1:0]     loc_c;
   logic [CH_W-1:0]     tloc_c;
   logic [DIE_W-1:0]    tloc_d;
   logic [COUNT_W-1:0]  cnt_cur;
   logic [COUNT_W-1:0]  cnt_dec;
   logic [COUNT_W-1:0]  limit_ext;
   logic [CAP_W-1:0]    bytes;
   logic [CAP_W:0]      used_sum;
   logic                room_ok;
   logic                cap_hit;
   logic                ch_found;
   logic [CH_W-1:0]     ch_found_idx;
   logic                die_found;
   logic [LOC_W-1:0]    die_found_idx;
   logic [TAG_W-1:0]    tag_raddr;
   logic [LOC_W-1:0]    die_raddr;
   logic                emit_valid;
   rsp_type             emit_data;

   function automatic rsp_type make_rsp(action_type act, logic [TAG_W-1:0] t,
                                        logic [CH_W-1:0] c, logic [DIE_W-1:0] d);
      rsp_type          r;
      logic [EV_TAG_W-1:0] t_x;
      logic [EV_CH_W-1:0]  c_x;
      logic [EV_DIE_W-1:0] d_x;
      t_x       = EV_TAG_W'(t);
      c_x       = EV_CH_W'(c);
      d_x       = EV_DIE_W'(d);
      r.action  = act;
      r.out_tag = t_x[8:0];
      r.channel = c_x[3:0];
      r.die     = d_x[1:0];
      r.last    = 1'b0;
      return r;
   endfunction

   assign ev_tag    = ev_ff.tag[TAG_W-1:0];
   assign new_loc   = {ev_ff.ch[CH_W-1:0], ev_ff.die[DIE_W-1:0]};
   assign loc_c     = loc_ff[LOC_W-1:DIE_W];
   assign tloc_c    = tloc_rd_ff[LOC_W-1:DIE_W];
   assign tloc_d    = tloc_rd_ff[DIE_W-1:0];
   assign cnt_cur   = cnt_vld_rd_ff ? cnt_rd_ff : '0;
   assign cnt_dec   = (cnt_cur != '0) ? cnt_cur - 1'b1 : '0;
   assign limit_ext = COUNT_W'(limit);
   assign bytes     = CAP_W'({tlen_rd_ff, 9'b0});
   assign used_sum  = {1'b0, used_ff} + {1'b0, bytes};
   assign room_ok   = (cap > used_ff) && ((cap - used_ff) > bytes);
   assign cap_hit   = (n_ff >= MAX_RESULTS);
   assign ev_pop    = (state_ff == ST_IDLE) && ev_valid;

   always_comb begin
      ch_found     = 1'b0;
      ch_found_idx = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (!ch_found && !ch_busy_ff[i] && chq_valid_ff[i] && (i >= int'(ch_cur_ff))) begin
            ch_found     = 1'b1;
            ch_found_idx = CH_W'(i);
         end
      end
   end

   always_comb begin
      die_found     = 1'b0;
      die_found_idx = '0;
      for (int i = 0; i < LOCS; i++) begin
         if (!die_found && !die_busy_ff[i] && dq_valid_ff[i] && (i >= int'(loc_cur_ff))) begin
            die_found     = 1'b1;
            die_found_idx = LOC_W'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (ev_valid) state_in = ST_EVT;
         ST_EVT:      state_in = (ev_ff.cmd == CMD_NEW_READ) ? ST_PUSH_DIE : ST_TAG;
         ST_PUSH_DIE: state_in = ST_HOST;
         ST_TAG:      state_in = (ev_ff.cmd == CMD_DIE_DONE) ? ST_CNT : ST_HOST;
         ST_CNT:      state_in = ST_HOST;
         ST_HOST:     state_in = (!host_busy_ff && hq_valid_ff) ? ST_HOST_POP : ST_CH_FIND;
         ST_HOST_POP: state_in = ST_CH_FIND;
         ST_CH_FIND:  state_in = (ch_found && !cap_hit) ? ST_CH_TAG : ST_DIE_FIND;
         ST_CH_TAG:   state_in = room_ok ? ST_CH_CNT : ST_CH_FIND;
         ST_CH_CNT:   state_in = ST_CH_FIND;
         ST_DIE_FIND: state_in = (die_found && !cap_hit) ? ST_DIE_HEAD : ST_DONE;
         ST_DIE_HEAD: state_in = ST_DIE_POP;
         ST_DIE_POP:  state_in = ST_DIE_FIND;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // read addresses and result beats
   always_comb begin
      tag_raddr  = ev_tag;
      die_raddr  = loc_ff;
      emit_valid = 1'b0;
      emit_data  = make_rsp(ACT_DIE_READ, '0, '0, '0);
      case (state_ff)
         ST_EVT: begin
            tag_raddr = ev_tag;
            die_raddr = new_loc;
         end
         ST_TAG:      die_raddr = tloc_rd_ff;
         ST_HOST:     tag_raddr = hq_head_ff;
         ST_HOST_POP: begin
            tag_raddr  = hq_head_ff;
            emit_valid = 1'b1;
            emit_data  = make_rsp(ACT_HOST_XFER, hq_head_ff, tloc_c, tloc_d);
         end
         ST_CH_FIND:  tag_raddr = chq_head_ff[ch_found_idx];
         ST_CH_TAG: begin
            tag_raddr = chq_head_ff[ch_sel_ff];
            die_raddr = tloc_rd_ff;
         end
         ST_CH_CNT: begin
            tag_raddr  = chq_head_ff[ch_sel_ff];
            emit_valid = 1'b1;
            emit_data  = make_rsp(ACT_CH_XFER, chq_head_ff[ch_sel_ff], ch_sel_ff,
                                  loc_ff[DIE_W-1:0]);
         end
         ST_DIE_FIND: die_raddr = die_found_idx;
         ST_DIE_HEAD: begin
            die_raddr = loc_sel_ff;
            tag_raddr = dhead_rd_ff;
         end
         ST_DIE_POP: begin
            die_raddr  = loc_sel_ff;
            tag_raddr  = dhead_rd_ff;
            emit_valid = 1'b1;
            emit_data  = make_rsp(ACT_DIE_READ, dhead_rd_ff, loc_sel_ff[LOC_W-1:DIE_W],
                                  loc_sel_ff[DIE_W-1:0]);
         end
         default: begin
         end
      endcase
   end

   // tag memories
   always_ff @(posedge clock) begin
      if (state_ff == ST_EVT && ev_ff.cmd == CMD_NEW_READ) begin
         tloc_mem[ev_tag] <= new_loc;
         tlen_mem[ev_tag] <= ev_ff.sectors;
      end
      if (state_ff == ST_PUSH_DIE && dq_valid_ff[loc_ff]) begin
         link_mem[dtail_rd_ff] <= ev_tag;
      end else if (state_ff == ST_TAG && ev_ff.cmd == CMD_CH_DONE && hq_valid_ff) begin
         link_mem[hq_tail_ff] <= ev_tag;
      end else if (state_ff == ST_CNT && chq_valid_ff[loc_c]) begin
         link_mem[chq_tail_ff[loc_c]] <= ev_tag;
      end
      link_rd_ff <= link_mem[tag_raddr];
      tloc_rd_ff <= tloc_mem[tag_raddr];
      tlen_rd_ff <= tlen_mem[tag_raddr];
   end

   // die memories
   always_ff @(posedge clock) begin
      if (state_ff == ST_PUSH_DIE) begin
         dtail_mem[loc_ff] <= ev_tag;
         if (!dq_valid_ff[loc_ff]) begin
            dhead_mem[loc_ff] <= ev_tag;
         end
      end else if (state_ff == ST_DIE_POP && dhead_rd_ff != dtail_rd_ff) begin
         dhead_mem[loc_sel_ff] <= link_rd_ff;
      end
      if (state_ff == ST_CNT) begin
         cnt_mem[loc_ff] <= (cnt_cur < COUNT_MAX) ? cnt_cur + 1'b1 : cnt_cur;
      end else if (state_ff == ST_CH_CNT) begin
         cnt_mem[loc_ff] <= cnt_dec;
      end
      dhead_rd_ff   <= dhead_mem[die_raddr];
      dtail_rd_ff   <= dtail_mem[die_raddr];
      cnt_rd_ff     <= cnt_mem[die_raddr];
      cnt_vld_rd_ff <= cnt_valid_ff[die_raddr];
   end

   // channel queue storage
   always_ff @(posedge clock) begin
      if (state_ff == ST_CNT) begin
         chq_tail_ff[loc_c] <= ev_tag;
         if (!chq_valid_ff[loc_c]) begin
            chq_head_ff[loc_c] <= ev_tag;
         end
      end else if (state_ff == ST_CH_CNT &&
                   chq_head_ff[ch_sel_ff] != chq_tail_ff[ch_sel_ff]) begin
         chq_head_ff[ch_sel_ff] <= link_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         ev_ff <= ev_data;
      end
      case (state_ff)
         ST_EVT:     loc_ff <= new_loc;
         ST_TAG:     loc_ff <= tloc_rd_ff;
         ST_CH_TAG:  loc_ff <= tloc_rd_ff;
         ST_CH_FIND: ch_sel_ff <= ch_found_idx;
         ST_DIE_FIND: loc_sel_ff <= die_found_idx;
         default: begin
         end
      endcase
      if (state_ff == ST_TAG && ev_ff.cmd == CMD_CH_DONE) begin
         hq_tail_ff <= ev_tag;
         if (!hq_valid_ff) begin
            hq_head_ff <= ev_tag;
         end
      end else if (state_ff == ST_HOST_POP && hq_head_ff != hq_tail_ff) begin
         hq_head_ff <= link_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         n_ff          <= '0;
         ch_cur_ff     <= '0;
         loc_cur_ff    <= '0;
         dq_valid_ff   <= '0;
         die_busy_ff   <= '0;
         cnt_valid_ff  <= '0;
         ch_busy_ff    <= '0;
         chq_valid_ff  <= '0;
         hq_valid_ff   <= 1'b0;
         host_busy_ff  <= 1'b0;
         used_ff       <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: n_ff <= '0;
            ST_PUSH_DIE: dq_valid_ff[loc_ff] <= 1'b1;
            ST_TAG: begin
               if (ev_ff.cmd == CMD_CH_DONE) begin
                  hq_valid_ff         <= 1'b1;
                  used_ff             <= (used_sum > {1'b0, USED_MAX}) ? USED_MAX
                                         : used_sum[CAP_W-1:0];
                  ch_busy_ff[tloc_c]  <= 1'b0;
               end else if (ev_ff.cmd == CMD_HOST_DONE) begin
                  host_busy_ff <= 1'b0;
                  used_ff      <= (used_ff < bytes) ? '0 : used_ff - bytes;
               end
            end
            ST_CNT: begin
               if (cnt_cur < limit_ext) begin
                  die_busy_ff[loc_ff] <= 1'b0;
               end
               cnt_valid_ff[loc_ff] <= 1'b1;
               chq_valid_ff[loc_c]  <= 1'b1;
            end
            ST_HOST: ch_cur_ff <= '0;
            ST_HOST_POP: begin
               host_busy_ff <= 1'b1;
               if (hq_head_ff == hq_tail_ff) begin
                  hq_valid_ff <= 1'b0;
               end
               n_ff <= n_ff + 1'b1;
            end
            ST_CH_FIND: loc_cur_ff <= '0;
            ST_CH_TAG: begin
               if (!room_ok) begin
                  ch_cur_ff <= {1'b0, ch_sel_ff} + 1'b1;
               end
            end
            ST_CH_CNT: begin
               if (cnt_dec < limit_ext) begin
                  die_busy_ff[loc_ff] <= 1'b0;
               end
               cnt_valid_ff[loc_ff]  <= 1'b1;
               ch_busy_ff[ch_sel_ff] <= 1'b1;
               if (chq_head_ff[ch_sel_ff] == chq_tail_ff[ch_sel_ff]) begin
                  chq_valid_ff[ch_sel_ff] <= 1'b0;
               end
               ch_cur_ff <= {1'b0, ch_sel_ff} + 1'b1;
               n_ff      <= n_ff + 1'b1;
            end
            ST_DIE_POP: begin
               die_busy_ff[loc_sel_ff] <= 1'b1;
               if (dhead_rd_ff == dtail_rd_ff) begin
                  dq_valid_ff[loc_sel_ff] <= 1'b0;
               end
               loc_cur_ff <= {1'b0, loc_sel_ff} + 1'b1;
               n_ff       <= n_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // one result held back so the final beat of an event can carry last
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (emit_valid) begin
            pend_valid_ff <= 1'b1;
            rsp_strobe_ff <= pend_valid_ff;
         end else if (state_ff == ST_DONE) begin
            pend_valid_ff <= 1'b0;
            rsp_strobe_ff <= pend_valid_ff;
         end
      end
   end

   always_comb begin
      pend_last      = pend_ff;
      pend_last.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (emit_valid) begin
         pend_ff <= emit_data;
         rsp_ff  <= pend_ff;
      end else if (state_ff == ST_DONE) begin
         rsp_ff <= pend_last;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `CHK_HOLDS(a_idle_no_pend, clock, reset, (state_ff == ST_IDLE) |-> !pend_valid_ff)
   `CHK_NEVER(a_result_cap, clock, reset, n_ff > MAX_RESULTS)
   `CHK_HOLDS(a_host_start, clock, reset, $rose(host_busy_ff) |-> ($past(state_ff) == ST_HOST_POP))

endmodule

FILE: rtl/core/flash_read_dispatch_scheduler.sv
// ---------------------------------------------------------------------------
// flash_read_dispatch_scheduler
// Schedules flash die reads, channel transfers and host transfers from
// completion events, using per-die, per-channel and host tag lists.
//
//   channel  ports                         beat
//   event    start / busy, req_data        cmd, tag, lba, sectors
//   result   rsp_strobe, rsp_data          action, out_tag, channel, die, last
//   config   csr_we, csr_index, csr_wdata  capacity, die limit
//
// The dispatch engine handles one event at a time, with single-port tag and
// die memories, and dispatches the host, then channels and dies, skipping a
// channel held off for lack of buffer room; it takes the next event only
// once it is back in idle.
// Two events queue in front of the engine; busy is high while both wait.
// Synchronous reset clears all lists, busy marks, counts and buffer use.
// Results are one-cycle strobed beats; the receiver cannot stall them.
// ---------------------------------------------------------------------------
module flash_read_dispatch_scheduler #(
   parameter int NUM_DIES     = 4,
   parameter int NUM_CHANNELS = 16,
   parameter int NUM_TAGS     = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  frds_pkg::req_type                  req_data,
   output logic                              rsp_strobe,
   output frds_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [frds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [frds_pkg::CAP_W-1:0]        csr_wdata
);
   import frds_pkg::*;

   logic [CAP_W-1:0]   cap_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               ev_valid;
   ev_type             ev_data;
   logic               ev_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAPACITY:  cap_ff   <= csr_wdata;
            CSR_DIE_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   frds_front #(
      .NUM_DIES     (NUM_DIES),
      .NUM_CHANNELS (NUM_CHANNELS),
      .NUM_TAGS     (NUM_TAGS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .ev_valid (ev_valid),
      .ev_data  (ev_data),
      .ev_pop   (ev_pop)
   );

   frds_back #(
      .NUM_DIES     (NUM_DIES),
      .NUM_CHANNELS (NUM_CHANNELS),
      .NUM_TAGS     (NUM_TAGS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .ev_valid   (ev_valid),
      .ev_data    (ev_data),
      .ev_pop     (ev_pop),
      .cap        (cap_ff),
      .limit      (limit_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
